[hw/rtl/cbps_pkg.sv]
// Shared types and constants for the crop box point statistics block.
// Used by cbps_dpath, cbps_ctrl, the top level and the checker; it depends on nothing else.
package cbps_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 24;

  localparam int OUT_W      = 112;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IS_Z    = 3'd6;

  localparam logic [22:0] BOX_SIZE_RST = 23'd6554;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_SINGLE   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_MEAN,
    S_MEAN_WAIT,
    S_DEV,
    S_DRAIN,
    S_VAR_WAIT,
    S_SQRT_WAIT,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic take;
    logic mean_start;
    logic mean_latch;
    logic dev_clear;
    logic dev_step;
    logic var_start;
    logic sqrt_start;
    logic load_out;
  } cbps_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic div_done;
    logic sqrt_done;
    logic dev_issued_all;
    logic dev_pipe_empty;
    logic out_free;
  } cbps_status_t;

endpackage

[hw/rtl/cbps_div.sv]
// Iterative restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on nothing but its parameter.
module cbps_div #(
  parameter int DIVW = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [63:0]     dividend,
  input  logic [DIVW-1:0] divisor,
  output logic            done,
  output logic [63:0]     quotient
);

  logic            busy;
  logic [5:0]      cnt;
  logic [DIVW-1:0] rem;
  logic [DIVW-1:0] dsr;
  logic [63:0]     quo;
  logic [DIVW:0]   sh;
  logic            ge;
  logic [DIVW-1:0] rem_next;

  always_comb begin
    sh       = {rem, quo[63]};
    ge       = sh >= {1'b0, dsr};
    rem_next = ge ? DIVW'(sh - {1'b0, dsr}) : DIVW'(sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/cbps_sqrt.sv]
// Digit-by-digit integer square root of a 64-bit value, rounded to nearest.
// Two radicand bits per cycle; depends on nothing else.
module cbps_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [32:0] root_rnd
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] src;
  logic [33:0] rem;
  logic [31:0] root;
  logic [35:0] sh;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    sh    = {rem, src[63:62]};
    trial = {2'b00, root, 2'b01};
    ge    = sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        src  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        src  <= {src[61:0], 2'b00};
        rem  <= ge ? 34'(sh - trial) : 34'(sh);
        root <= {root[30:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root_rnd = (rem > {2'b00, root}) ? 33'({1'b0, root} + 33'd1) : {1'b0, root};

endmodule

[hw/rtl/cbps_dpath.sv]
// Datapath: configuration registers, crop test, depth store, running statistics,
// deviation pass, result register. Uses cbps_pkg, cbps_div and cbps_sqrt.
module cbps_dpath #(
  parameter int MAX_POINTS = cbps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cbps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_BITS-1:0]        point_x,
  input  logic signed [COORD_BITS-1:0]        point_y,
  input  logic signed [COORD_BITS-1:0]        point_z,
  input  cbps_pkg::cbps_cmd_t                 cmd,
  output cbps_pkg::cbps_status_t              status,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cbps_pkg::OUT_W-1:0]          m_tdata
);
  import cbps_pkg::*;

  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int SW   = COORD_BITS + NW;
  localparam int MNW  = COORD_BITS + 1;
  localparam int DIVW = NW + 1;
  localparam int CW   = ((COORD_BITS > 25) ? COORD_BITS : 25) + 2;

  logic signed [23:0] center_x, center_y, center_z, column_offset, row_offset;
  logic        [22:0] box_size;
  logic               depth_is_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      box_size      <= BOX_SIZE_RST;
      column_offset <= '0;
      row_offset    <= '0;
      depth_is_z    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:      center_x      <= signed'(cfg_data);
        CFG_CENTER_Y:      center_y      <= signed'(cfg_data);
        CFG_CENTER_Z:      center_z      <= signed'(cfg_data);
        CFG_BOX_SIZE:      box_size      <= cfg_data[22:0];
        CFG_COLUMN_OFFSET: column_offset <= signed'(cfg_data);
        CFG_ROW_OFFSET:    row_offset    <= signed'(cfg_data);
        CFG_DEPTH_IS_Z:    depth_is_z    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic signed [24:0]   cx, cy, cz;
  logic signed [CW-1:0] dx2, dy2, dz2, bs;
  logic                 in_box;
  logic signed [COORD_BITS-1:0] depth, lat0;

  always_comb begin
    cx     = 25'(center_x) + 25'(column_offset);
    cy     = 25'(center_y) + 25'(row_offset);
    cz     = 25'(center_z);
    dx2    = (CW'(point_x) - CW'(cx)) <<< 1;
    dy2    = (CW'(point_y) - CW'(cy)) <<< 1;
    dz2    = (CW'(point_z) - CW'(cz)) <<< 1;
    bs     = signed'(CW'(box_size));
    in_box = (dx2 >= -bs) && (dx2 <= bs) && (dy2 >= -bs) && (dy2 <= bs) &&
             (dz2 >= -bs) && (dz2 <= bs);
    depth  = depth_is_z ? point_z : point_x;
    lat0   = depth_is_z ? point_x : point_z;
  end

  logic [NW-1:0]                kept_count;
  logic signed [SW-1:0]         depth_sum;
  logic signed [COORD_BITS-1:0] lmin0, lmin1, lmax0, lmax1;
  logic                         ovf;
  logic [63:0]                  dev_sum;
  logic                         full;
  logic                         mem_we;

  assign full   = kept_count == NW'(MAX_POINTS);
  assign mem_we = cmd.take && in_box && !full;

  logic [COORD_BITS-1:0] depth_store [MAX_POINTS];
  logic [NW-1:0]         rd_ptr;
  logic [COORD_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_store[kept_count[AW-1:0]] <= depth;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= depth_store[rd_ptr[AW-1:0]];
  end

  logic signed [MNW-1:0] mean;
  logic                  v1, v2, v3;
  logic [COORD_BITS+1:0] mag;
  logic [63:0]           sq;
  logic signed [COORD_BITS+1:0] diff;
  logic [63:0]           mag64;
  logic [64:0]           acc;

  always_comb begin
    diff  = (COORD_BITS + 2)'(signed'(rd_data)) - (COORD_BITS + 2)'(mean);
    mag64 = 64'(mag);
    acc   = 65'(dev_sum) + 65'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      depth_sum  <= '0;
      ovf        <= 1'b0;
      dev_sum    <= '0;
      lmin0      <= {1'b0, {(COORD_BITS - 1){1'b1}}};
      lmin1      <= {1'b0, {(COORD_BITS - 1){1'b1}}};
      lmax0      <= {1'b1, {(COORD_BITS - 1){1'b0}}};
      lmax1      <= {1'b1, {(COORD_BITS - 1){1'b0}}};
      rd_ptr     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        kept_count <= '0;
        depth_sum  <= '0;
        ovf        <= 1'b0;
        dev_sum    <= '0;
        lmin0      <= {1'b0, {(COORD_BITS - 1){1'b1}}};
        lmin1      <= {1'b0, {(COORD_BITS - 1){1'b1}}};
        lmax0      <= {1'b1, {(COORD_BITS - 1){1'b0}}};
        lmax1      <= {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else if (cmd.take && in_box) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          kept_count <= kept_count + NW'(1);
          depth_sum  <= depth_sum + SW'(depth);
          if (lat0 < lmin0) lmin0 <= lat0;
          if (lat0 > lmax0) lmax0 <= lat0;
          if (point_y < lmin1) lmin1 <= point_y;
          if (point_y > lmax1) lmax1 <= point_y;
        end
      end
      if (cmd.dev_clear) begin
        rd_ptr <= '0;
      end else if (cmd.dev_step && !status.dev_issued_all) begin
        rd_ptr <= rd_ptr + NW'(1);
      end
      v1 <= cmd.dev_step && !status.dev_issued_all;
      v2 <= v1;
      v3 <= v2;
      if (v3 && !cmd.load_out) begin
        dev_sum <= acc[64] ? '1 : acc[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mag <= diff[COORD_BITS+1] ? (COORD_BITS + 2)'(-diff) : (COORD_BITS + 2)'(diff);
    sq  <= ((mag64 >> 32) != 64'd0) ? '1 : mag64[31:0] * mag64[31:0];
  end

  logic                 sum_neg;
  logic [SW-1:0]        sum_mag;
  logic [63:0]          div_dividend;
  logic [DIVW-1:0]      div_divisor;
  logic                 div_done;
  logic [63:0]          quotient;
  logic                 sqrt_done;
  logic [32:0]          root_rnd;
  logic signed [MNW-1:0] qs;

  always_comb begin
    sum_neg = depth_sum[SW-1];
    sum_mag = sum_neg ? SW'(-depth_sum) : SW'(depth_sum);
    if (cmd.var_start) begin
      div_dividend = dev_sum;
      div_divisor  = DIVW'(kept_count - NW'(1));
    end else begin
      div_dividend = 64'({sum_mag, 1'b0}) + 64'(kept_count);
      div_divisor  = {kept_count, 1'b0};
    end
    qs = signed'(quotient[MNW-1:0]);
  end

  cbps_div #(.DIVW(DIVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mean_start || cmd.var_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  cbps_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (quotient),
    .done     (sqrt_done),
    .root_rnd (root_rnd)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_latch) begin
      mean <= sum_neg ? -qs : qs;
    end
  end

  logic signed [33:0] mean34;
  logic [33:0]        w34, h34;
  logic [23:0]        mean_o, sd_o, w_o, h_o;
  logic [12:0]        pi_o;
  logic [1:0]         st_o;
  logic               n_zero, n_one;

  always_comb begin
    n_zero = kept_count == '0;
    n_one  = kept_count == NW'(1);
    mean34 = 34'(mean);
    w34    = 34'((COORD_BITS + 1)'(lmax0) - (COORD_BITS + 1)'(lmin0));
    h34    = 34'((COORD_BITS + 1)'(lmax1) - (COORD_BITS + 1)'(lmin1));
    if (n_zero) begin
      mean_o = '0;
      w_o    = '0;
      h_o    = '0;
    end else begin
      if (mean34 > 34'sd8388607) begin
        mean_o = 24'h7FFFFF;
      end else if (mean34 < -34'sd8388608) begin
        mean_o = 24'h800000;
      end else begin
        mean_o = mean34[23:0];
      end
      w_o = (w34 > 34'd16777215) ? 24'hFFFFFF : w34[23:0];
      h_o = (h34 > 34'd16777215) ? 24'hFFFFFF : h34[23:0];
    end
    if (n_zero || n_one) begin
      sd_o = '0;
    end else begin
      sd_o = (root_rnd > 33'd16777215) ? 24'hFFFFFF : root_rnd[23:0];
    end
    pi_o = (32'(kept_count) > 32'd8191) ? 13'h1FFF : 13'(kept_count);
    if (ovf) begin
      st_o = ST_OVERFLOW;
    end else if (n_zero) begin
      st_o = ST_EMPTY;
    end else if (n_one) begin
      st_o = ST_SINGLE;
    end else begin
      st_o = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {1'b0, st_o, pi_o, h_o, w_o, sd_o, mean_o};
    end
  end

  always_comb begin
    status.n_zero         = n_zero;
    status.n_one          = n_one;
    status.div_done       = div_done;
    status.sqrt_done      = sqrt_done;
    status.dev_issued_all = rd_ptr == kept_count;
    status.dev_pipe_empty = !v1 && !v2 && !v3;
    status.out_free       = !m_tvalid || m_tready;
  end

endmodule

[hw/rtl/cbps_ctrl.sv]
// Controller state machine: point collection, mean, deviation pass, variance,
// root and result hand-off. Uses cbps_pkg; drives the datapath by commands.
module cbps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tlast,
  output logic                   s_tready,
  input  cbps_pkg::cbps_status_t status,
  output cbps_pkg::cbps_cmd_t    cmd
);
  import cbps_pkg::*;

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT:   if (s_tvalid && s_tlast) state_next = S_MEAN;
      S_MEAN:      state_next = status.n_zero ? S_FINISH : S_MEAN_WAIT;
      S_MEAN_WAIT: if (status.div_done) state_next = S_DEV;
      S_DEV:       if (status.dev_issued_all) state_next = S_DRAIN;
      S_DRAIN: begin
        if (status.dev_pipe_empty) state_next = status.n_one ? S_FINISH : S_VAR_WAIT;
      end
      S_VAR_WAIT:  if (status.div_done) state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (status.sqrt_done) state_next = S_FINISH;
      S_FINISH:    if (status.out_free) state_next = S_COLLECT;
      default:     state_next = S_COLLECT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_COLLECT: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      S_MEAN:      cmd.mean_start = !status.n_zero;
      S_MEAN_WAIT: begin
        cmd.mean_latch = status.div_done;
        cmd.dev_clear  = status.div_done;
      end
      S_DEV:       cmd.dev_step = 1'b1;
      S_DRAIN:     cmd.var_start = status.dev_pipe_empty && !status.n_one;
      S_VAR_WAIT:  cmd.sqrt_start = status.div_done;
      S_SQRT_WAIT: ;
      S_FINISH:    cmd.load_out = status.out_free;
      default:     ;
    endcase
  end

endmodule

[hw/rtl/crop_box_point_statistics.sv]
// Top level of the crop box point statistics block.
// Joins cbps_ctrl and cbps_dpath; uses cbps_pkg.
//
//  Channel  Signals                                 Beat carries
//  s_*      s_tvalid s_tready s_tdata s_tlast       one point, tlast ends the cloud
//  m_*      m_tvalid m_tready m_tdata               one cloud's statistics
//  cfg_*    cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// Points are taken one per cycle. After the tlast beat the input stalls while the result is worked out:
// the mean divide is started and runs to its end, the deviation pass reads back the N kept points,
// then the variance divide, the root and the load of the result beat follow.
// An empty cloud goes straight to the load, and a single point cloud skips the variance and root.
// Reset is synchronous and restores the register defaults and empty statistics.
// A result waiting on m_tready holds the next cloud only when that cloud ends.
module crop_box_point_statistics #(
  parameter int MAX_POINTS = cbps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cbps_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_x, point_y, point_z, zero fill
  input  logic [((3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mean_depth, std_dev, extent_width, extent_height, points_inside, status, zero fill
  output logic [cbps_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbps_pkg::*;

  cbps_cmd_t    cmd;
  cbps_status_t status;

  assign cfg_ready = 1'b1;

  cbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cbps_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point_x   (signed'(s_tdata[COORD_BITS-1:0])),
    .point_y   (signed'(s_tdata[2*COORD_BITS-1:COORD_BITS])),
    .point_z   (signed'(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[hw/rtl/cbps_checker.sv]
// Port-level checks on the result stream of crop_box_point_statistics.
// Uses cbps_pkg; bound to the top level at the end of this file.
module cbps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [cbps_pkg::OUT_W-1:0] m_tdata
);
  import cbps_pkg::*;

  logic [23:0] mean_f, sd_f, w_f, h_f;
  logic [12:0] pi_f;
  logic [1:0]  st_f;

  assign mean_f = m_tdata[23:0];
  assign sd_f   = m_tdata[47:24];
  assign w_f    = m_tdata[71:48];
  assign h_f    = m_tdata[95:72];
  assign pi_f   = m_tdata[108:96];
  assign st_f   = m_tdata[110:109];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st_f == ST_EMPTY |-> pi_f == 13'd0 && mean_f == 24'd0 && sd_f == 24'd0
      && w_f == 24'd0 && h_f == 24'd0)
    else $error("empty cloud reports nonzero fields");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st_f == ST_SINGLE |-> pi_f == 13'd1 && sd_f == 24'd0
      && w_f == 24'd0 && h_f == 24'd0)
    else $error("single point cloud reports spread");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st_f == ST_OK |-> pi_f > 13'd1)
    else $error("ok status with fewer than two points");

endmodule

bind crop_box_point_statistics cbps_checker u_cbps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
